FILE: sv/sfc_pkg.sv
`timescale 1ns / 1ps
// sfc_pkg: shared types and constants for the sphere frustum classifier.
// No dependencies.
package sfc_pkg;

  localparam int NUM_PLANES        = 6;
  localparam int REJECT_ONLY_PLANE = 4;
  localparam int COORD_W           = 16;
  localparam int RAD_W             = 15;
  localparam int CFG_W             = 64;
  localparam int CFG_IDX_W         = 3;
  localparam int BOUNDS_W          = 48;
  // box stage, two stages per plane cell, output register
  localparam int PIPE_LAT          = 2 + 2 * NUM_PLANES;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_0    = 3'd0,
    CFG_PLANE_1    = 3'd1,
    CFG_PLANE_2    = 3'd2,
    CFG_PLANE_3    = 3'd3,
    CFG_PLANE_4    = 3'd4,
    CFG_PLANE_5    = 3'd5,
    CFG_BOUNDS_MIN = 3'd6,
    CFG_BOUNDS_MAX = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VIS_OUTSIDE  = 2'd0,
    VIS_STRADDLE = 2'd1,
    VIS_INSIDE   = 2'd2
  } vis_e;

  typedef struct packed {
    logic                       valid;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic signed [COORD_W-1:0]  cz;
    logic        [RAD_W-1:0]    radius;
    logic                       outside;
    logic                       strad;
  } sfc_tok_t;

endpackage

FILE: sv/sfc_box.sv
`timescale 1ns / 1ps
// sfc_box: world-box reject stage at the head of the cell chain.
// Holds the bounds registers. Depends on sfc_pkg.
module sfc_box import sfc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  sfc_tok_t               tok_i,
  output sfc_tok_t               tok_o
);

  logic [BOUNDS_W-1:0] bmin_q, bmax_q;
  sfc_tok_t            tok_d, tok_q;

  function automatic logic axis_out(logic signed [COORD_W-1:0] c,
                                    logic [RAD_W-1:0] r,
                                    logic [COORD_W-1:0] lo,
                                    logic [COORD_W-1:0] hi);
    logic signed [COORD_W+1:0] c_lo, c_hi, lo_e, hi_e;
    c_lo = {{2{c[COORD_W-1]}}, c} - $signed({3'b000, r});
    c_hi = {{2{c[COORD_W-1]}}, c} + $signed({3'b000, r});
    lo_e = $signed({{2{lo[COORD_W-1]}}, lo});
    hi_e = $signed({{2{hi[COORD_W-1]}}, hi});
    return (hi_e < c_lo) || (lo_e > c_hi);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bmin_q <= '0;
      bmax_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_BOUNDS_MIN) bmin_q <= cfg_wdata_i[BOUNDS_W-1:0];
      if (cfg_idx_i == CFG_BOUNDS_MAX) bmax_q <= cfg_wdata_i[BOUNDS_W-1:0];
    end
  end

  always_comb begin
    tok_d         = tok_i;
    tok_d.strad   = 1'b0;
    tok_d.outside = axis_out(tok_i.cx, tok_i.radius, bmin_q[47:32], bmax_q[47:32])
                 || axis_out(tok_i.cy, tok_i.radius, bmin_q[31:16], bmax_q[31:16])
                 || axis_out(tok_i.cz, tok_i.radius, bmin_q[15:0],  bmax_q[15:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: sv/sfc_cell.sv
`timescale 1ns / 1ps
// sfc_cell: one plane of the frustum; holds the plane register, forms the
// signed distance over two stages and updates the request's flags. Depends on sfc_pkg.
module sfc_cell import sfc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [CFG_W-1:0] wdata_i,
  input  logic             straddle_en_i,
  input  sfc_tok_t         tok_i,
  output sfc_tok_t         tok_o
);

  localparam int PROD_W = 2 * COORD_W;
  localparam int DIST_W = PROD_W + 3;

  logic [CFG_W-1:0]           plane_q;
  logic signed [COORD_W-1:0]  nx, ny, nz;
  logic signed [PROD_W-1:0]   prod_x_d, prod_y_d, prod_z_d;
  logic signed [PROD_W-1:0]   prod_x_q, prod_y_q, prod_z_q;
  sfc_tok_t                   tok_a_q, tok_d, tok_q;
  logic signed [DIST_W-1:0]   psum, d_ext, pdist, rs, neg_rs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (we_i) begin
      plane_q <= wdata_i;
    end
  end

  assign nx = $signed(plane_q[63:48]);
  assign ny = $signed(plane_q[47:32]);
  assign nz = $signed(plane_q[31:16]);

  assign prod_x_d = nx * tok_i.cx;
  assign prod_y_d = ny * tok_i.cy;
  assign prod_z_d = nz * tok_i.cz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_a_q <= '0;
    end else begin
      tok_a_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_x_q <= prod_x_d;
    prod_y_q <= prod_y_d;
    prod_z_q <= prod_z_d;
  end

  always_comb begin
    psum   = {{3{prod_x_q[PROD_W-1]}}, prod_x_q}
           + {{3{prod_y_q[PROD_W-1]}}, prod_y_q}
           + {{3{prod_z_q[PROD_W-1]}}, prod_z_q};
    d_ext  = $signed({{(DIST_W-COORD_W-14){plane_q[15]}}, plane_q[15:0], 14'b0});
    pdist  = psum - d_ext;
    rs     = $signed({{(DIST_W-RAD_W-14){1'b0}}, tok_a_q.radius, 14'b0});
    neg_rs = -rs;
    tok_d         = tok_a_q;
    tok_d.outside = tok_a_q.outside || (pdist > rs);
    tok_d.strad   = tok_a_q.strad || (straddle_en_i && (pdist >= neg_rs));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: sv/sphere_frustum_classifier_core.sv
`timescale 1ns / 1ps
// sphere_frustum_classifier_core: top level, box stage plus a chain of six
// plane cells and an output register. Depends on sfc_pkg, sfc_box, sfc_cell.
//
// Usage:
//  - Request: drive center_x_i/y_i/z_i and radius_i with start_i high. busy_o
//    is always low, so a request is taken at every edge where start_i is high.
//  - Result: done_o pulses for one cycle with visibility_o valid
//    (0 outside, 1 straddles a plane other than plane 4, 2 otherwise).
//  - Pipeline: from the accepting edge a request passes one box stage, two
//    stages in each of the six plane cells (product register, then sum and
//    compare), and the output register, which holds the result.
//  - Throughput: one request per cycle; each cell works on a different
//    request every cycle and passes it to its neighbor.
//  - Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//    (0..5 planes, 6 bounds min, 7 bounds max). Write only while no request
//    is in flight.
//  - Reset clears all registers but the cells' product registers to zero and empties the pipeline.
//  - There is no back-pressure: results must be taken when done_o is high.
module sphere_frustum_classifier_core import sfc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [COORD_W-1:0] center_x_i,
  input  logic signed [COORD_W-1:0] center_y_i,
  input  logic signed [COORD_W-1:0] center_z_i,
  input  logic [RAD_W-1:0]          radius_i,
  output logic                      done_o,
  output logic [1:0]                visibility_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_wdata_i
);

  sfc_tok_t tok_in;
  sfc_tok_t tok [NUM_PLANES+1];
  logic     done_q;
  vis_e     vis_d, vis_q;

  assign busy_o = 1'b0;

  always_comb begin
    tok_in         = '0;
    tok_in.valid   = start_i && !busy_o;
    tok_in.cx      = center_x_i;
    tok_in.cy      = center_y_i;
    tok_in.cz      = center_z_i;
    tok_in.radius  = radius_i;
  end

  sfc_box u_box (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .tok_i      (tok_in),
    .tok_o      (tok[0])
  );

  for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
    sfc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .we_i         (cfg_we_i && (cfg_idx_i == CFG_IDX_W'(k))),
      .wdata_i      (cfg_wdata_i),
      .straddle_en_i(k != REJECT_ONLY_PLANE),
      .tok_i        (tok[k]),
      .tok_o        (tok[k+1])
    );
  end

  always_comb begin
    if (tok[NUM_PLANES].outside) begin
      vis_d = VIS_OUTSIDE;
    end else if (tok[NUM_PLANES].strad) begin
      vis_d = VIS_STRADDLE;
    end else begin
      vis_d = VIS_INSIDE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      vis_q  <= VIS_OUTSIDE;
    end else begin
      done_q <= tok[NUM_PLANES].valid;
      vis_q  <= vis_d;
    end
  end

  assign done_o       = done_q;
  assign visibility_o = vis_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(PIPE_LAT) done_o)
    else $error("request did not complete after fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(tok[0].valid, PIPE_LAT - 1))
    else $error("result without a matching request");

  a_vis_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (visibility_o == VIS_OUTSIDE || visibility_o == VIS_STRADDLE
                || visibility_o == VIS_INSIDE))
    else $error("result carries an undefined visibility code");

endmodule
